// File: hw/rtl/range_encoder_static_model_defines.svh
// ----------------------------------------------------------------------------
// Range encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_ENCODER_STATIC_MODEL_DEFINES_SVH
`define RANGE_ENCODER_STATIC_MODEL_DEFINES_SVH

// The property holds at every clock edge outside reset.
`define RESM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define RESM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/resm_pkg.sv
// ----------------------------------------------------------------------------
// Range encoder package
// Constants, action codes and the queue entry shared by the encoder modules.
// ----------------------------------------------------------------------------
package resm_pkg;

	localparam int NUM_SYMBOLS = 257;
	localparam int TABLE_DEPTH = NUM_SYMBOLS + 1;
	localparam int IDX_W       = 9;
	localparam int VAL_W       = 25;
	localparam int LOW_BYTES   = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [VAL_W-1:0] TOTAL_LIMIT = 25'h1000000;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_FLUSH  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// One job for the back end: a flush, or an encode with its table entries.
	typedef struct packed {
		logic             is_flush;
		logic [VAL_W-1:0] lo_c;
		logic [VAL_W-1:0] hi_c;
		logic [VAL_W-1:0] total;
	} job_t;

endpackage

// File: hw/rtl/resm_queue.sv
// ----------------------------------------------------------------------------
// Range encoder job queue
// Two-entry queue that decouples the table front end from the coder back end.
// ----------------------------------------------------------------------------
module resm_queue import resm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_data
);

	job_t       slot_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'(QUEUE_DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hw/rtl/resm_front.sv
// ----------------------------------------------------------------------------
// Range encoder front end
// Accepts input words, keeps the cumulative table and queues coder jobs.
// ----------------------------------------------------------------------------
module resm_front import resm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [IDX_W-1:0] symbol,
	input  logic [IDX_W-1:0] table_index,
	input  logic [VAL_W-1:0] table_value,
	output logic             push,
	output job_t             push_data,
	input  logic             full
);

	logic [VAL_W-1:0] mem [TABLE_DEPTH];
	logic [VAL_W-1:0] rd_lo_q;
	logic [VAL_W-1:0] rd_hi_q;
	logic [VAL_W-1:0] total_q;
	logic             pend_q;
	logic             acc;
	logic             enc_ok;

	assign in_ready = !pend_q && !full;
	assign acc      = in_valid && in_ready;
	assign enc_ok   = (action == ACT_ENCODE) && (symbol < IDX_W'(NUM_SYMBOLS));

	// A pending encode is pushed in the cycle after it is accepted, once its table reads are registered.
	assign push = pend_q || (acc && action == ACT_FLUSH);
	always_comb begin
		push_data.is_flush = !pend_q;
		push_data.lo_c     = rd_lo_q;
		push_data.hi_c     = rd_hi_q;
		push_data.total    = total_q;
	end

	always_ff @(posedge clk) begin
		if (acc && action == ACT_LOAD && table_index < IDX_W'(TABLE_DEPTH)) begin
			mem[table_index] <= table_value;
		end
		if (acc && enc_ok) begin
			rd_lo_q <= mem[symbol];
			rd_hi_q <= mem[symbol + IDX_W'(1)];
		end
		// The total lives in its own register so it needs no third read port.
		if (acc && action == ACT_LOAD && table_index == IDX_W'(NUM_SYMBOLS)) begin
			total_q <= table_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= acc && enc_ok;
		end
	end

endmodule

// File: hw/rtl/resm_back.sv
// ----------------------------------------------------------------------------
// Range encoder back end
// Divides, narrows the interval, renormalizes, flushes and drives the output register.
// ----------------------------------------------------------------------------
`include "range_encoder_static_model_defines.svh"

module resm_back import resm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_data,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DIV    = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_RENORM = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t           st_q;
	logic [31:0]      low_q;
	logic [31:0]      range_q;
	logic [VAL_W-1:0] lo_q;
	logic [VAL_W-1:0] freq_q;
	logic [VAL_W-1:0] total_q;
	logic [VAL_W-1:0] rem_q;
	logic [31:0]      dvd_q;
	logic [4:0]       div_cnt_q;
	logic             mul_sel_q;
	logic [31:0]      prod_lo_q;
	logic [2:0]       rn_cnt_q;
	logic             hold_v_q;
	logic [7:0]       hold_byte_q;
	logic [1:0]       fl_cnt_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;

	logic             job_ok;
	logic [VAL_W:0]   trial;
	logic             ge;
	logic [VAL_W-1:0] mul_op;
	logic [56:0]      prod;
	logic [31:0]      sum;
	logic             big;
	logic             cont;
	logic [31:0]      neg_low;
	logic             can_push;
	logic             push_en;
	logic [7:0]       push_byte;
	logic             push_last;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	assign pop    = (st_q == ST_IDLE) && head_valid;
	assign job_ok = (head_data.total != '0) && (head_data.total <= TOTAL_LIMIT)
		&& (head_data.hi_c > head_data.lo_c) && (head_data.hi_c <= head_data.total);

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, dvd_q[31]};
	assign ge    = trial >= {1'b0, total_q};

	assign mul_op = mul_sel_q ? freq_q : lo_q;
	assign prod   = 57'(dvd_q) * 57'(mul_op);

	assign sum     = low_q + range_q;
	assign big     = (low_q[31:24] ^ sum[31:24]) != 8'd0;
	assign cont    = (rn_cnt_q < 3'(LOW_BYTES)) && (!big || range_q[31:24] == 8'd0);
	assign neg_low = 32'd0 - low_q;

	assign can_push = !out_valid_q || out_ready;

	always_comb begin
		push_en   = 1'b0;
		push_byte = hold_byte_q;
		push_last = 1'b0;
		if (st_q == ST_RENORM && hold_v_q && can_push) begin
			push_en   = 1'b1;
			push_last = !cont;
		end else if (st_q == ST_FLUSH && can_push) begin
			push_en   = 1'b1;
			push_byte = low_q[31:24];
			push_last = (fl_cnt_q == 2'(LOW_BYTES - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			out_byte_q <= push_byte;
			last_q     <= push_last;
		end
		if (pop) begin
			lo_q    <= head_data.lo_c;
			freq_q  <= head_data.hi_c - head_data.lo_c;
			total_q <= head_data.total;
		end
		if (st_q == ST_MUL && !mul_sel_q) begin
			prod_lo_q <= prod[31:0];
		end
		if (st_q == ST_RENORM && cont && (!hold_v_q || can_push)) begin
			hold_byte_q <= low_q[31:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			low_q       <= '0;
			range_q     <= '1;
			rem_q       <= '0;
			dvd_q       <= '0;
			div_cnt_q   <= '0;
			mul_sel_q   <= 1'b0;
			rn_cnt_q    <= '0;
			hold_v_q    <= 1'b0;
			fl_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (head_data.is_flush) begin
							fl_cnt_q <= '0;
							st_q     <= ST_FLUSH;
						end else if (job_ok) begin
							rem_q     <= '0;
							dvd_q     <= range_q;
							div_cnt_q <= '0;
							st_q      <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q     <= ge ? VAL_W'(trial - {1'b0, total_q}) : VAL_W'(trial);
					dvd_q     <= {dvd_q[30:0], ge};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						mul_sel_q <= 1'b0;
						st_q      <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_sel_q <= 1'b1;
					if (mul_sel_q) begin
						low_q    <= low_q + prod_lo_q;
						range_q  <= prod[31:0];
						rn_cnt_q <= '0;
						hold_v_q <= 1'b0;
						st_q     <= ST_RENORM;
					end
				end
				ST_RENORM: begin
					if (cont) begin
						if (!hold_v_q || can_push) begin
							hold_v_q <= 1'b1;
							low_q    <= {low_q[23:0], 8'd0};
							// Snap the range to the next top-byte boundary when it straddles.
							range_q  <= big ? {neg_low[23:0], 8'd0} : {range_q[23:0], 8'd0};
							rn_cnt_q <= rn_cnt_q + 3'd1;
						end
					end else if (!hold_v_q || can_push) begin
						hold_v_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (can_push) begin
						low_q    <= {low_q[23:0], 8'd0};
						fl_cnt_q <= fl_cnt_q + 2'd1;
						if (fl_cnt_q == 2'(LOW_BYTES - 1)) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RESM_ASSERT_IMP(a_hold_in_renorm, hold_v_q, st_q == ST_RENORM, "held byte outside renorm")
	`RESM_ASSERT(a_renorm_bound, rn_cnt_q <= 3'(LOW_BYTES), "renorm emitted too many bytes")
	`RESM_ASSERT_IMP(a_mul_total, st_q == ST_MUL, total_q != '0, "multiply with zero total")

endmodule

// File: hw/rtl/range_encoder_static_model.sv
// ----------------------------------------------------------------------------
// Carryless range encoder, static model
// Top level: table front end, job queue and arithmetic coder back end.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Word
//  in      | in_valid / in_ready  | action, symbol, table_index, table_value
//  out     | out_valid / out_ready| out_byte, last
//
// An encode has its table reads registered in the front end. The back end takes it
// from the queue, divides in the bit-serial divider, multiplies twice in the shared
// multiplier (low term, then range), renormalizes byte by byte and finishes.
// A flush is taken and then emits the four bytes of low. Up to two jobs wait in the
// queue, so the input keeps flowing while output stalls until the queue is full.
// Reset clears the coder interval; table entries are undefined until loaded.
module range_encoder_static_model import resm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [IDX_W-1:0] symbol,
	input  logic [IDX_W-1:0] table_index,
	input  logic [VAL_W-1:0] table_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last
);

	logic push;
	job_t push_data;
	logic full;
	logic pop;
	logic head_valid;
	job_t head_data;

	resm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.symbol      (symbol),
		.table_index (table_index),
		.table_value (table_value),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	resm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	resm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last       (last)
	);

endmodule
